[rtl/core/kset_pkg.sv]
// package for the key state edge tracker: request codes, flag bit positions,
// widths and the flag update rule for key events
// no dependencies
package kset_pkg;

  localparam int KEY_W = 9;
  localparam int KEY_COUNT_DEF = 512;
  localparam int FLAG_W = 3;

  localparam int FLAG_HELD = 0;
  localparam int FLAG_PRESSED = 1;
  localparam int FLAG_RELEASED = 2;

  localparam logic [FLAG_W-1:0] KEEP_HELD = 3'b001;
  localparam logic [FLAG_W-1:0] KEEP_NONE = 3'b000;

  localparam logic KIND_CHANGE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [1:0] {
    REQ_KEY_EVENT  = 2'd0,
    REQ_END_FRAME  = 2'd1,
    REQ_FULL_CLEAR = 2'd2,
    REQ_QUERY      = 2'd3
  } req_type_e;

  typedef logic [FLAG_W-1:0] flags_t;

  function automatic flags_t apply_event(input flags_t f, input logic down);
    flags_t nf;
    nf = f;
    if (down) begin
      nf[FLAG_HELD] = 1'b1;
      nf[FLAG_PRESSED] = 1'b1;
    end else begin
      nf[FLAG_HELD] = 1'b0;
      nf[FLAG_RELEASED] = 1'b1;
    end
    return nf;
  endfunction

endpackage

[rtl/core/kset_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module kset_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/key_state_edge_tracker.sv]
// key state edge tracker top level: request sequencer, flag store and touched list
// depends on kset_pkg and kset_ram
//
//   channel   handshake            payload
//   request   start, busy          req_type_i, key_code_i, key_down_i
//   result    done_o (one cycle)   result_kind_o, key_out_o, held_o,
//                                  pressed_edge_o, released_edge_o
//
// key events and queries: flag ram read on acceptance, lookup writes back changed flags
// queries and held state changes report on the cycle after lookup, with busy low again
// end of frame and full clear walk the touched list and empty it afterwards:
// the list walk reads one list entry and one flag entry per cycle through a three stage
// ram pipeline
// after reset the flag ram is cleared one entry a cycle, busy high until it is done
// the result side cannot stall, every result is shown for exactly one cycle
module key_state_edge_tracker
  import kset_pkg::*;
#(
  parameter int KEY_COUNT = KEY_COUNT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       req_type_i,
  input  logic [KEY_W-1:0] key_code_i,
  input  logic             key_down_i,
  output logic             done_o,
  output logic             result_kind_o,
  output logic [KEY_W-1:0] key_out_o,
  output logic             held_o,
  output logic             pressed_edge_o,
  output logic             released_edge_o
);

  localparam int AW = $clog2(KEY_COUNT);
  localparam int CW = AW + 1;
  localparam int EW = ((AW > KEY_W) ? AW : KEY_W) + 1;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_LOOKUP = 4'b0100,
    ST_WALK   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0] clr_idx_q, clr_idx_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] walk_idx_q, walk_idx_d;
  logic v1_q, v2_q;
  logic [AW-1:0] key2_q;

  req_type_e req_q;
  logic [KEY_W-1:0] key_q;
  logic down_q;

  logic done_q, done_d;
  logic kind_q, kind_d;
  logic [KEY_W-1:0] kout_q, kout_d;
  flags_t rflags_q, rflags_d;

  logic flags_we;
  logic [AW-1:0] flags_waddr, flags_raddr;
  flags_t flags_wdata, flags_rdata;
  logic list_we;
  logic [AW-1:0] list_rdata;

  logic [EW-1:0] in_ext, q_ext;
  logic [AW-1:0] in_addr, q_addr;
  logic q_in_range;
  logic accept;
  logic rd_issue;
  logic walk_done;
  logic ev_change;
  logic listed;
  flags_t new_flags;
  flags_t keep;

  assign accept = start && !busy;
  assign busy = (state_q != ST_IDLE);

  assign in_ext = EW'(key_code_i);
  assign in_addr = in_ext[AW-1:0];
  assign q_ext = EW'(key_q);
  assign q_addr = q_ext[AW-1:0];
  assign q_in_range = (q_ext < EW'(KEY_COUNT));

  assign rd_issue = (state_q == ST_WALK) && (walk_idx_q < cnt_q);
  assign walk_done = (state_q == ST_WALK) && !rd_issue && !v1_q && !v2_q;
  assign keep = (req_q == REQ_END_FRAME) ? KEEP_HELD : KEEP_NONE;

  assign ev_change = q_in_range && (down_q != flags_rdata[FLAG_HELD]);
  assign listed = flags_rdata[FLAG_PRESSED] | flags_rdata[FLAG_RELEASED];
  assign new_flags = apply_event(flags_rdata, down_q);

  assign flags_raddr = (state_q == ST_IDLE) ? in_addr : list_rdata;

  kset_ram #(
    .Width(FLAG_W),
    .Depth(KEY_COUNT)
  ) u_flags_ram (
    .clk_i  (clk_i),
    .we_i   (flags_we),
    .waddr_i(flags_waddr),
    .wdata_i(flags_wdata),
    .raddr_i(flags_raddr),
    .rdata_o(flags_rdata)
  );

  kset_ram #(
    .Width(AW),
    .Depth(KEY_COUNT)
  ) u_list_ram (
    .clk_i  (clk_i),
    .we_i   (list_we),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i(q_addr),
    .raddr_i(walk_idx_q[AW-1:0]),
    .rdata_o(list_rdata)
  );

  always_comb begin
    state_d = state_q;
    clr_idx_d = clr_idx_q;
    cnt_d = cnt_q;
    walk_idx_d = walk_idx_q;
    flags_we = 1'b0;
    flags_waddr = q_addr;
    flags_wdata = new_flags;
    list_we = 1'b0;
    done_d = 1'b0;
    kind_d = kind_q;
    kout_d = kout_q;
    rflags_d = rflags_q;
    unique case (state_q)
      ST_CLEAR: begin
        flags_we = 1'b1;
        flags_waddr = clr_idx_q;
        flags_wdata = '0;
        if (clr_idx_q == AW'(KEY_COUNT - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_idx_d = clr_idx_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_d = ST_IDLE;
        unique case (req_q)
          REQ_KEY_EVENT: begin
            if (ev_change) begin
              flags_we = 1'b1;
              done_d = 1'b1;
              kind_d = KIND_CHANGE;
              kout_d = key_q;
              rflags_d = new_flags;
              if (!listed && (cnt_q < CW'(KEY_COUNT))) begin
                list_we = 1'b1;
                cnt_d = cnt_q + 1'b1;
              end
            end
          end
          REQ_QUERY: begin
            done_d = 1'b1;
            kind_d = KIND_QUERY;
            kout_d = key_q;
            rflags_d = q_in_range ? flags_rdata : '0;
          end
          REQ_END_FRAME, REQ_FULL_CLEAR: begin
            state_d = ST_WALK;
            walk_idx_d = '0;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_WALK: begin
        if (v2_q) begin
          flags_we = 1'b1;
          flags_waddr = key2_q;
          flags_wdata = flags_rdata & keep;
        end
        if (rd_issue) begin
          walk_idx_d = walk_idx_q + 1'b1;
        end
        if (walk_done) begin
          state_d = ST_IDLE;
          cnt_d = '0;
        end
      end
      default: begin
        state_d = ST_CLEAR;
        clr_idx_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_idx_q <= '0;
      cnt_q <= '0;
      walk_idx_q <= '0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_idx_q <= clr_idx_d;
      cnt_q <= cnt_d;
      walk_idx_q <= walk_idx_d;
      v1_q <= rd_issue;
      v2_q <= v1_q;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_type_e'(req_type_i);
      key_q <= key_code_i;
      down_q <= key_down_i;
    end
    key2_q <= list_rdata;
    kind_q <= kind_d;
    kout_q <= kout_d;
    rflags_q <= rflags_d;
  end

  assign done_o = done_q;
  assign result_kind_o = kind_q;
  assign key_out_o = kout_q;
  assign held_o = rflags_q[FLAG_HELD];
  assign pressed_edge_o = rflags_q[FLAG_PRESSED];
  assign released_edge_o = rflags_q[FLAG_RELEASED];

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for two cycles");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(KEY_COUNT))
    else $error("touched count beyond key count");

  a_accept_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_LOOKUP))
    else $error("accepted item did not reach lookup");

  a_walk_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_done |=> (cnt_q == '0) && !v1_q && !v2_q)
    else $error("touched list not emptied after walk");

endmodule

[bench/key_state_edge_tracker_tb.sv]
`timescale 1ns / 1ps
// self-checking bench for key_state_edge_tracker: directed and random request items
// against a flag and touched-list predictor held in a small scoreboard class
// depends on kset_pkg and the key_state_edge_tracker rtl
module key_state_edge_tracker_tb;
  import kset_pkg::*;

  class key_flag_scoreboard;
    typedef struct {
      logic             kind;
      logic [KEY_W-1:0] key;
      flags_t           flags;
    } key_result_t;

    flags_t           flags [KEY_COUNT_DEF];
    logic [KEY_W-1:0] touched [$];
    key_result_t      expected [$];
    int               errors;

    function new();
      foreach (flags[i]) flags[i] = '0;
      errors = 0;
    endfunction

    function bit is_held(logic [KEY_W-1:0] key);
      return flags[key][FLAG_HELD];
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function void push_result(logic kind, logic [KEY_W-1:0] key, flags_t f);
      key_result_t r;
      r.kind = kind;
      r.key = key;
      r.flags = f;
      expected.push_back(r);
    endfunction

    function void note_item(req_type_e req, logic [KEY_W-1:0] key, logic down);
      flags_t f;
      f = flags[key];
      case (req)
        REQ_KEY_EVENT: begin
          if (down != f[FLAG_HELD]) begin
            if (!f[FLAG_PRESSED] && !f[FLAG_RELEASED]) touched.push_back(key);
            f[FLAG_HELD] = down;
            if (down) f[FLAG_PRESSED] = 1'b1;
            else f[FLAG_RELEASED] = 1'b1;
            flags[key] = f;
            push_result(KIND_CHANGE, key, f);
          end
        end
        REQ_END_FRAME: begin
          foreach (touched[i]) flags[touched[i]] = flags[touched[i]] & KEEP_HELD;
          touched.delete();
        end
        REQ_FULL_CLEAR: begin
          foreach (touched[i]) flags[touched[i]] = flags[touched[i]] & KEEP_NONE;
          touched.delete();
        end
        default: push_result(KIND_QUERY, key, f);
      endcase
    endfunction

    task report(string msg);
      if (errors < 40) $display("%0t ns  mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic kind, logic [KEY_W-1:0] key, logic held, logic pr, logic rel);
      key_result_t e;
      if (expected.size() == 0) begin
        report($sformatf("result with nothing expected, key %0d", key));
        return;
      end
      e = expected.pop_front();
      if (kind !== e.kind) report($sformatf("key %0d kind %b, want %b", e.key, kind, e.kind));
      if (key !== e.key) report($sformatf("key %0d, want %0d", key, e.key));
      if (held !== e.flags[FLAG_HELD])
        report($sformatf("key %0d held %b, want %b", e.key, held, e.flags[FLAG_HELD]));
      if (pr !== e.flags[FLAG_PRESSED])
        report($sformatf("key %0d pressed %b, want %b", e.key, pr, e.flags[FLAG_PRESSED]));
      if (rel !== e.flags[FLAG_RELEASED])
        report($sformatf("key %0d released %b, want %b", e.key, rel, e.flags[FLAG_RELEASED]));
    endtask
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       req_type_i = REQ_QUERY;
  logic [KEY_W-1:0] key_code_i = '0;
  logic             key_down_i = 1'b0;
  logic             done_o;
  logic             result_kind_o;
  logic [KEY_W-1:0] key_out_o;
  logic             held_o;
  logic             pressed_edge_o;
  logic             released_edge_o;

  key_flag_scoreboard sb = new();

  key_state_edge_tracker dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .key_code_i     (key_code_i),
    .key_down_i     (key_down_i),
    .done_o         (done_o),
    .result_kind_o  (result_kind_o),
    .key_out_o      (key_out_o),
    .held_o         (held_o),
    .pressed_edge_o (pressed_edge_o),
    .released_edge_o(released_edge_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_result(result_kind_o, key_out_o, held_o, pressed_edge_o, released_edge_o);
  end

  task automatic send_item(req_type_e req, logic [KEY_W-1:0] key, logic down);
    start <= 1'b1;
    req_type_i <= req;
    key_code_i <= key;
    key_down_i <= down;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_item(req, key, down);
  endtask

  task automatic sender_gap(int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < pct);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // mostly a small pool of keys at both ends so frames build real histories
  task automatic run_random(int pct, int count);
    int               sel;
    int               done_items;
    req_type_e        req;
    logic [KEY_W-1:0] key;
    logic             down;
    done_items = 0;
    while (done_items < count) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) req = REQ_KEY_EVENT;
      else if (sel < 77) req = REQ_END_FRAME;
      else if (sel < 80) req = REQ_FULL_CLEAR;
      else req = REQ_QUERY;
      if ($urandom_range(0, 9) < 8)
        key = $urandom_range(0, 1) ? KEY_W'($urandom_range(496, 511))
                                   : KEY_W'($urandom_range(0, 15));
      else
        key = KEY_W'($urandom_range(0, 511));
      down = ($urandom_range(0, 9) < 8) ? !sb.is_held(key) : 1'($urandom_range(0, 1));
      if (req != REQ_KEY_EVENT || down != sb.is_held(key)) done_items++;
      sender_gap(pct);
      send_item(req, key, down);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(REQ_KEY_EVENT, 9'd0, 1'b1);
    send_item(REQ_KEY_EVENT, 9'd511, 1'b1);
    send_item(REQ_KEY_EVENT, 9'd0, 1'b1);
    send_item(REQ_KEY_EVENT, 9'd5, 1'b0);
    send_item(REQ_QUERY, 9'd0, 1'b0);
    send_item(REQ_QUERY, 9'd511, 1'b1);
    send_item(REQ_KEY_EVENT, 9'd0, 1'b0);
    // press again in the same frame, already listed
    send_item(REQ_KEY_EVENT, 9'd0, 1'b1);
    send_item(REQ_QUERY, 9'd0, 1'b0);
    send_item(REQ_END_FRAME, 9'd0, 1'b0);
    send_item(REQ_QUERY, 9'd0, 1'b0);
    // held keys outside the list survive a full clear
    send_item(REQ_FULL_CLEAR, 9'd511, 1'b1);
    send_item(REQ_QUERY, 9'd511, 1'b0);
    send_item(REQ_KEY_EVENT, 9'd511, 1'b0);
    send_item(REQ_FULL_CLEAR, 9'd0, 1'b0);
    send_item(REQ_QUERY, 9'd511, 1'b0);
    send_item(REQ_QUERY, 9'd0, 1'b0);
    send_item(REQ_QUERY, 9'h155, 1'b1);
    send_item(REQ_QUERY, 9'h0aa, 1'b0);
    drain_results();

    run_random(0, 380);
    drain_results();
    run_random(85, 380);
    drain_results();
    run_random(26, 390);

    drain_results();
    repeat (16) @(posedge clk_i);
    if (sb.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[sim.f]
rtl/core/kset_pkg.sv
rtl/core/kset_ram.sv
rtl/core/key_state_edge_tracker.sv
bench/key_state_edge_tracker_tb.sv
